// ===== src/fba_pkg.sv =====
// Package of the flash block allocator: sizes, command codes, controller states,
// datapath operations and the status record. Used by every other file.
package fba_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int FIELD_W    = 12;
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = BLK_W + 1;
    localparam int WIDE_W     = 2 * FIELD_W + 1;
    localparam int ROW_BITS   = 64;
    localparam int ROW_W      = $clog2(ROW_BITS);
    localparam int ROWS       = MAX_BLOCKS / ROW_BITS;
    localparam int ROWIDX_W   = $clog2(ROWS);
    localparam int ZSL_W      = 4;
    localparam int BCNT_W     = 13;
    localparam int LOG_MAX    = 12;

    localparam logic [ZSL_W-1:0]  ZSL_RESET  = ZSL_W'(6);
    localparam logic [BCNT_W-1:0] BCNT_RESET = BCNT_W'(4096);

    localparam logic CFG_ZONE_SIZE_LOG = 1'b0;
    localparam logic CFG_BLOCK_COUNT   = 1'b1;

    typedef enum logic [1:0] {
        CMD_GET        = 2'd0,
        CMD_PUT        = 2'd1,
        CMD_RESET_ZONE = 2'd2,
        CMD_RESET_ALL  = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_RESULT,
        S_G_SELRD, S_G_SEL, S_G_RD, S_G_EVAL,
        S_PR_RD, S_PR_EVAL, S_GR_RD, S_GR_WR,
        S_P_SELRD, S_P_SEL, S_P_RD, S_P_WR,
        S_Z_RD, S_Z_WR, S_Z_SRD, S_Z_SWR,
        S_A_CLR
    } state_t;

    typedef enum logic [3:0] {
        OP_NOP, OP_LOAD, OP_SEL_RD, OP_SEL_LATCH, OP_MAP_RD, OP_SCAN_NEXT,
        OP_FIRST_HIT, OP_FLIP, OP_PREF_HIT, OP_GRANT_RD, OP_GRANT_WR,
        OP_PUT_WR, OP_Z_RD, OP_Z_WR, OP_ZS_WR, OP_CLR_ALL
    } dp_op_t;

    // Result-producing op for commands that report nothing: an alias of OP_NOP.
    localparam dp_op_t OP_RES_ZERO = OP_NOP;

    typedef struct packed {
        cmd_t cmd;
        logic empty;
        logic oob;
        logic zoff_ok;
        logic hit;
        logic hit_pref;
        logic f_ok;
        logic last;
        logic len_one;
        logic second;
        logic zrow_last;
        logic res_free;
    } dp_stat_t;

    typedef struct packed {
        dp_op_t op;
        logic   res_zero;
    } dp_ctl_t;

    typedef struct packed {
        logic [ROW_BITS-1:0] dirty;
        logic [ROW_BITS-1:0] used_b;
        logic [ROW_BITS-1:0] used_a;
    } map_row_t;

endpackage

// ===== src/fba_if.sv =====
// Channel interfaces of the flash block allocator: request words in, result words out.
// Depends on fba_pkg for field widths.
interface fba_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   command;
    logic [fba_pkg::FIELD_W-1:0]  zone;
    logic [fba_pkg::FIELD_W-1:0]  block;
    logic                         dirty;
    logic [fba_pkg::FIELD_W-1:0]  random_offset;
    modport source (output valid, command, zone, block, dirty, random_offset, input ready);
    modport sink   (input valid, command, zone, block, dirty, random_offset, output ready);
endinterface

interface fba_out_if;
    logic                         valid;
    logic                         ready;
    logic [fba_pkg::FIELD_W-1:0]  allocated_block;
    logic                         found;
    logic                         block_dirty;
    modport source (output valid, allocated_block, found, block_dirty, input ready);
    modport sink   (input valid, allocated_block, found, block_dirty, output ready);
endinterface

// ===== src/fba_datapath.sv =====
// Datapath of the flash block allocator: configuration, bitmap and selector memories,
// scan registers and the result register. Depends on fba_pkg.
module fba_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [fba_pkg::BCNT_W-1:0]    cfg_data,
    input  fba_pkg::dp_ctl_t              ctl,
    output fba_pkg::dp_stat_t             stat,
    input  logic [1:0]                    in_command,
    input  logic [fba_pkg::FIELD_W-1:0]   in_zone,
    input  logic [fba_pkg::FIELD_W-1:0]   in_block,
    input  logic                          in_dirty,
    input  logic [fba_pkg::FIELD_W-1:0]   in_random_offset,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [fba_pkg::FIELD_W-1:0]   out_allocated_block,
    output logic                          out_found,
    output logic                          out_block_dirty
);
    import fba_pkg::*;

    logic [ZSL_W-1:0]  zsl_reg;
    logic [BCNT_W-1:0] bcount_reg;

    cmd_t              cmd_reg;
    logic              want_reg, empty_reg, oob_reg, zoff_ok_reg, msel_reg, second_reg;
    logic [CNT_W-1:0]  zmin_reg, zmax_reg, start_reg, k_reg;
    logic [BLK_W-1:0]  pos_reg, c_reg, sel_addr_reg;
    logic [ROWIDX_W-1:0] row_reg;
    logic [WIDE_W-1:0] zoff_reg, zend_reg;

    map_row_t          map_mem [ROWS];
    logic [ROWS-1:0]   map_vld_reg;
    map_row_t          map_rd_reg;
    logic [ROW_BITS-1:0] sel_mem [ROWS];
    logic [ROWS-1:0]   sel_vld_reg;
    logic [ROW_BITS-1:0] sel_rd_reg;

    logic              out_valid_reg, res_found_reg, res_dirty_reg;
    logic [FIELD_W-1:0] res_block_reg;

    // Configuration and its effective values.
    logic [ZSL_W-1:0]  lg;
    logic [CNT_W-1:0]  cnt;
    logic [WIDE_W-1:0] cntw, zoneoff, zmaxw, zmaxc, startw, startc, sizew;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zsl_reg    <= ZSL_RESET;
            bcount_reg <= BCNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ZONE_SIZE_LOG: zsl_reg    <= cfg_data[ZSL_W-1:0];
                CFG_BLOCK_COUNT:   bcount_reg <= cfg_data;
                default:           zsl_reg    <= zsl_reg;
            endcase
        end
    end

    always_comb
    begin
        lg      = (zsl_reg > ZSL_W'(LOG_MAX)) ? ZSL_W'(LOG_MAX) : zsl_reg;
        cnt     = (WIDE_W'(bcount_reg) > WIDE_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                              : CNT_W'(bcount_reg);
        cntw    = WIDE_W'(cnt);
        sizew   = WIDE_W'(1) << lg;
        zoneoff = WIDE_W'(in_zone) << lg;
        zmaxw   = (WIDE_W'(in_zone) + WIDE_W'(1)) << lg;
        zmaxc   = (zmaxw > cntw) ? cntw : zmaxw;
        startw  = zoneoff + (WIDE_W'(in_random_offset) & (sizew - WIDE_W'(1)));
        startc  = (startw >= cntw) ? (cntw - WIDE_W'(1)) : startw;
    end

    // Bits of the buffered row at the scan position.
    logic [ROW_W-1:0]  bo, bc;
    logic              ua, ub, dy, free_bit;
    logic [CNT_W-1:0]  len, pos_p1, pos_nxt;

    always_comb
    begin
        bo       = pos_reg[ROW_W-1:0];
        bc       = c_reg[ROW_W-1:0];
        ua       = map_rd_reg.used_a[bo];
        ub       = map_rd_reg.used_b[bo];
        dy       = map_rd_reg.dirty[bo];
        free_bit = !(msel_reg ? ub : ua);
        len      = zmax_reg - zmin_reg;
        pos_p1   = CNT_W'(pos_reg) + CNT_W'(1);
        pos_nxt  = (pos_p1 == zmax_reg) ? zmin_reg : pos_p1;
    end

    always_comb
    begin
        stat.cmd       = cmd_reg;
        stat.empty     = empty_reg;
        stat.oob       = oob_reg;
        stat.zoff_ok   = zoff_ok_reg;
        stat.hit       = free_bit;
        stat.hit_pref  = free_bit && (dy == want_reg);
        stat.f_ok      = (dy == want_reg);
        stat.last      = (k_reg == len - CNT_W'(1));
        stat.len_one   = (len == CNT_W'(1));
        stat.second    = second_reg;
        stat.zrow_last = (row_reg == ROWIDX_W'(ROWS - 1))
                      || (((WIDE_W'(row_reg) + WIDE_W'(1)) << ROW_W) >= zend_reg);
        stat.res_free  = !out_valid_reg || out_ready;
    end

    // Scan and request registers.
    always_ff @(posedge clk)
    begin
        unique case (ctl.op)
            OP_LOAD:
            begin
                cmd_reg      <= cmd_t'(in_command);
                want_reg     <= in_dirty;
                empty_reg    <= zoneoff >= cntw;
                oob_reg      <= WIDE_W'(in_block) >= cntw;
                zoff_ok_reg  <= zoneoff < WIDE_W'(MAX_BLOCKS);
                zmin_reg     <= CNT_W'(zoneoff);
                zmax_reg     <= CNT_W'(zmaxc);
                start_reg    <= CNT_W'(startc);
                k_reg        <= '0;
                second_reg   <= 1'b0;
                row_reg      <= zoneoff[BLK_W-1:ROW_W];
                zoff_reg     <= zoneoff;
                zend_reg     <= zoneoff + sizew;
                if (cmd_t'(in_command) == CMD_PUT)
                begin
                    pos_reg      <= BLK_W'(in_block);
                    sel_addr_reg <= BLK_W'(in_block >> lg);
                end
                else
                begin
                    pos_reg      <= BLK_W'(startc);
                    sel_addr_reg <= BLK_W'(in_zone);
                end
            end
            OP_SEL_LATCH: msel_reg <= sel_rd_reg[sel_addr_reg[ROW_W-1:0]];
            OP_SCAN_NEXT:
            begin
                pos_reg <= BLK_W'(pos_nxt);
                k_reg   <= k_reg + CNT_W'(1);
            end
            OP_FIRST_HIT:
            begin
                c_reg   <= pos_reg;
                pos_reg <= BLK_W'(pos_nxt);
                k_reg   <= CNT_W'(1);
            end
            OP_FLIP:
            begin
                msel_reg   <= !msel_reg;
                second_reg <= 1'b1;
                pos_reg    <= BLK_W'(start_reg);
                k_reg      <= '0;
            end
            OP_PREF_HIT: c_reg <= pos_reg;
            OP_Z_WR:     row_reg <= row_reg + ROWIDX_W'(1);
            default:     k_reg <= k_reg;
        endcase
    end

    // Bitmap memory with read-modify-write rows.
    logic              map_re, map_we;
    logic [ROWIDX_W-1:0] map_raddr, map_waddr;
    map_row_t          map_wdata;
    logic [WIDE_W-1:0] q;

    always_comb
    begin
        map_re    = 1'b0;
        map_we    = 1'b0;
        map_raddr = pos_reg[BLK_W-1:ROW_W];
        map_waddr = pos_reg[BLK_W-1:ROW_W];
        map_wdata = map_rd_reg;
        q         = '0;
        unique case (ctl.op)
            OP_MAP_RD:   map_re = 1'b1;
            OP_GRANT_RD:
            begin
                map_re    = 1'b1;
                map_raddr = c_reg[BLK_W-1:ROW_W];
            end
            OP_Z_RD:
            begin
                map_re    = 1'b1;
                map_raddr = row_reg;
            end
            OP_GRANT_WR:
            begin
                map_we               = 1'b1;
                map_waddr            = c_reg[BLK_W-1:ROW_W];
                map_wdata.used_a[bc] = 1'b1;
                map_wdata.used_b[bc] = 1'b1;
                map_wdata.dirty[bc]  = 1'b1;
            end
            OP_PUT_WR:
            begin
                map_we               = 1'b1;
                map_wdata.used_a[bo] = !msel_reg;
                map_wdata.used_b[bo] = msel_reg;
                if (!want_reg)
                begin
                    map_wdata.dirty[bo] = 1'b0;
                end
            end
            OP_Z_WR:
            begin
                map_we    = 1'b1;
                map_waddr = row_reg;
                for (int i = 0; i < ROW_BITS; i++)
                begin
                    q = (WIDE_W'(row_reg) << ROW_W) + WIDE_W'(i);
                    if (q >= zoff_reg && q < zend_reg)
                    begin
                        map_wdata.used_a[i] = 1'b1;
                        map_wdata.used_b[i] = 1'b1;
                        map_wdata.dirty[i]  = 1'b1;
                    end
                end
            end
            default: map_re = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (map_re)
        begin
            map_rd_reg <= map_vld_reg[map_raddr] ? map_mem[map_raddr] : '1;
        end
    end

    // Selector memory; an untouched row reads as all zero.
    logic              sel_we;
    logic [ROW_BITS-1:0] sel_wdata;
    logic [ROWIDX_W-1:0] sel_addr;

    always_comb
    begin
        sel_addr  = sel_addr_reg[BLK_W-1:ROW_W];
        sel_we    = (ctl.op == OP_FLIP) || (ctl.op == OP_ZS_WR);
        sel_wdata = sel_rd_reg;
        if (ctl.op == OP_FLIP)
        begin
            sel_wdata[sel_addr_reg[ROW_W-1:0]] = !msel_reg;
        end
        else
        begin
            sel_wdata[sel_addr_reg[ROW_W-1:0]] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel_we)
        begin
            sel_mem[sel_addr] <= sel_wdata;
        end
        if (ctl.op == OP_SEL_RD)
        begin
            sel_rd_reg <= sel_vld_reg[sel_addr] ? sel_mem[sel_addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_vld_reg <= '0;
            sel_vld_reg <= '0;
        end
        else if (ctl.op == OP_CLR_ALL)
        begin
            map_vld_reg <= '0;
            sel_vld_reg <= '0;
        end
        else
        begin
            if (map_we)
            begin
                map_vld_reg[map_waddr] <= 1'b1;
            end
            if (sel_we)
            begin
                sel_vld_reg[sel_addr] <= 1'b1;
            end
        end
    end

    // Result register.
    logic res_load;
    assign res_load = ctl.res_zero || (ctl.op == OP_GRANT_WR) || (ctl.op == OP_PUT_WR)
                   || (ctl.op == OP_ZS_WR) || (ctl.op == OP_CLR_ALL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            if (ctl.op == OP_GRANT_WR)
            begin
                res_block_reg <= FIELD_W'(c_reg);
                res_found_reg <= 1'b1;
                res_dirty_reg <= map_rd_reg.dirty[bc];
            end
            else
            begin
                res_block_reg <= '0;
                res_found_reg <= 1'b0;
                res_dirty_reg <= 1'b0;
            end
        end
    end

    assign out_valid           = out_valid_reg;
    assign out_allocated_block = res_block_reg;
    assign out_found           = res_found_reg;
    assign out_block_dirty     = res_dirty_reg;

endmodule

// ===== src/fba_controller.sv =====
// Controller state machine of the flash block allocator: sequences scans and map updates.
// Depends on fba_pkg; drives fba_datapath through its op code.
module fba_controller (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  fba_pkg::dp_stat_t  stat,
    output fba_pkg::dp_ctl_t   ctl
);
    import fba_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ctl.op       = OP_NOP;
        ctl.res_zero = 1'b0;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.cmd)
                    CMD_GET:        state_next = stat.empty ? S_RESULT : S_G_SELRD;
                    CMD_PUT:        state_next = stat.oob ? S_RESULT : S_P_SELRD;
                    CMD_RESET_ZONE: state_next = stat.zoff_ok ? S_Z_RD : S_Z_SRD;
                    CMD_RESET_ALL:  state_next = S_A_CLR;
                    default:        state_next = S_RESULT;
                endcase
            end
            S_RESULT:
            begin
                if (stat.res_free)
                begin
                    ctl.op       = OP_RES_ZERO;
                    ctl.res_zero = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_G_SELRD:
            begin
                ctl.op     = OP_SEL_RD;
                state_next = S_G_SEL;
            end
            S_G_SEL:
            begin
                ctl.op     = OP_SEL_LATCH;
                state_next = S_G_RD;
            end
            S_G_RD:
            begin
                ctl.op     = OP_MAP_RD;
                state_next = S_G_EVAL;
            end
            S_G_EVAL:
            begin
                priority if (stat.hit)
                begin
                    ctl.op     = OP_FIRST_HIT;
                    state_next = (stat.f_ok || stat.len_one) ? S_GR_RD : S_PR_RD;
                end
                else if (stat.last && stat.second)
                begin
                    state_next = S_RESULT;
                end
                else if (stat.last)
                begin
                    ctl.op     = OP_FLIP;
                    state_next = S_G_RD;
                end
                else
                begin
                    ctl.op     = OP_SCAN_NEXT;
                    state_next = S_G_RD;
                end
            end
            S_PR_RD:
            begin
                ctl.op     = OP_MAP_RD;
                state_next = S_PR_EVAL;
            end
            S_PR_EVAL:
            begin
                priority if (stat.hit_pref)
                begin
                    ctl.op     = OP_PREF_HIT;
                    state_next = S_GR_RD;
                end
                else if (stat.last)
                begin
                    state_next = S_GR_RD;
                end
                else
                begin
                    ctl.op     = OP_SCAN_NEXT;
                    state_next = S_PR_RD;
                end
            end
            S_GR_RD:
            begin
                ctl.op     = OP_GRANT_RD;
                state_next = S_GR_WR;
            end
            S_GR_WR:
            begin
                if (stat.res_free)
                begin
                    ctl.op     = OP_GRANT_WR;
                    state_next = S_IDLE;
                end
            end
            S_P_SELRD:
            begin
                ctl.op     = OP_SEL_RD;
                state_next = S_P_SEL;
            end
            S_P_SEL:
            begin
                ctl.op     = OP_SEL_LATCH;
                state_next = S_P_RD;
            end
            S_P_RD:
            begin
                ctl.op     = OP_MAP_RD;
                state_next = S_P_WR;
            end
            S_P_WR:
            begin
                if (stat.res_free)
                begin
                    ctl.op     = OP_PUT_WR;
                    state_next = S_IDLE;
                end
            end
            S_Z_RD:
            begin
                ctl.op     = OP_Z_RD;
                state_next = S_Z_WR;
            end
            S_Z_WR:
            begin
                ctl.op     = OP_Z_WR;
                state_next = stat.zrow_last ? S_Z_SRD : S_Z_RD;
            end
            S_Z_SRD:
            begin
                ctl.op     = OP_SEL_RD;
                state_next = S_Z_SWR;
            end
            S_Z_SWR:
            begin
                if (stat.res_free)
                begin
                    ctl.op     = OP_ZS_WR;
                    state_next = S_IDLE;
                end
            end
            S_A_CLR:
            begin
                if (stat.res_free)
                begin
                    ctl.op     = OP_CLR_ALL;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== src/flash_block_allocator_top.sv =====
// Top level of the flash block allocator: controller, datapath and channel ports.
// Depends on fba_pkg, fba_if, fba_controller and fba_datapath.
//
// Usage: one request word enters on in_ch (command, zone, block, dirty,
// random_offset) and exactly one result word leaves on out_ch for each request.
// The block takes one request at a time; in_ch.ready is high only while idle.
// Steps per request, from acceptance to the result being registered:
//   get:        each scanned position costs a row read of the bitmap memory
//               and one compare. A full search covers both maps plus the dirty
//               preference scan over the zone.
//   put:        selector read, row read, row write.
//   reset zone: a row read and a row write per 64-block row touched by the zone.
//   reset all:  every bitmap and selector row is marked untouched.
//   A get on an empty zone or a put beyond the block count skips to the result.
// Reset clears the controller and the per-row valid flags, so after reset all
// blocks read as used and dirty and all selectors as zero without a sweep.
// A result waits in the output register while out_ch stalls; the next request
// may be accepted meanwhile, and its result is held back until the first is taken.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user must
// do so only while idle, as the block itself does not enforce it.
module flash_block_allocator_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [fba_pkg::BCNT_W-1:0]  cfg_data,
    fba_in_if.sink                      in_ch,
    fba_out_if.source                   out_ch
);
    import fba_pkg::*;

    dp_ctl_t  ctl;
    dp_stat_t stat;

    // Sequencer: takes requests and steps the datapath through each command.
    fba_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // Datapath: configuration, maps, scan position and result register.
    fba_datapath u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .ctl                 (ctl),
        .stat                (stat),
        .in_command          (in_ch.command),
        .in_zone             (in_ch.zone),
        .in_block            (in_ch.block),
        .in_dirty            (in_ch.dirty),
        .in_random_offset    (in_ch.random_offset),
        .out_ready           (out_ch.ready),
        .out_valid           (out_ch.valid),
        .out_allocated_block (out_ch.allocated_block),
        .out_found           (out_ch.found),
        .out_block_dirty     (out_ch.block_dirty)
    );

endmodule
